/* design/point_heightmap_builder_assert.svh */
// Assertion macros shared by the height grid checker.
`ifndef POINT_HEIGHTMAP_BUILDER_ASSERT_SVH
`define POINT_HEIGHTMAP_BUILDER_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define PHB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define PHB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* design/phb_pkg.sv */
// Types and constants of the point height grid builder.
package phb_pkg;

    // Operation codes of an input beat; the fourth code is ignored.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POINT = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    // Cell classes reported by a query.
    localparam logic [1:0] CLASS_NONE     = 2'd0;
    localparam logic [1:0] CLASS_GROUND   = 2'd1;
    localparam logic [1:0] CLASS_OBSTACLE = 2'd2;
    localparam logic [1:0] CLASS_BETWEEN  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CELL_SIZE  = 3'd0;
    localparam logic [2:0] CFG_HALF_X     = 3'd1;
    localparam logic [2:0] CFG_HALF_Y     = 3'd2;
    localparam logic [2:0] CFG_MAX_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_GROUND     = 3'd4;
    localparam logic [2:0] CFG_OBSTACLE   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_CELL_SIZE  = 10'd100;
    localparam logic [14:0] RST_HALF       = 15'd5000;
    localparam logic [11:0] RST_MAX_HEIGHT = 12'd2000;
    localparam logic [11:0] RST_GROUND     = 12'd50;
    localparam logic [11:0] RST_OBSTACLE   = 12'd100;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_P_DIV,
        S_CHK,
        S_P_ADDR,
        S_P_RD,
        S_Q_RD0,
        S_Q_C,
        S_Q_NB,
        S_Q_LAST,
        S_Q_SUM,
        S_Q_DIV
    } state_t;

endpackage

/* design/point_heightmap_builder.sv */
// Top level of the point height grid builder.
//
// Usage: drive an item with start while busy is low. The grid lives in one
// single-port RAM of CELLS_X*CELLS_Y entries (occupied flag and 12-bit height),
// and every access goes through that one port. After reset and after each
// clear beat the block sweeps the RAM one entry per cycle with busy high. A
// point beat keeps busy high through the row and column division, the map
// check and, for a cell inside the map, the read and possible write of that
// cell; a point dropped on z or sign leaves busy low. A query keeps busy high
// through the map check and the read of its cell; an empty cell inside the map
// then reads its neighbours one per cycle and sums them, and an average is
// divided out when there is one. The query result appears on result_valid for
// exactly one cycle, in the same cycle as busy falls, and cannot be held off.
// The user must make configuration writes only while the block is idle; the
// block itself does not enforce this.
module point_heightmap_builder #(
    parameter int CELLS_X = 128,
    parameter int CELLS_Y = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] x_mm,
    input  logic signed [15:0] y_mm,
    input  logic signed [15:0] z_mm,
    input  logic [6:0]         query_row,
    input  logic [6:0]         query_col,
    output logic               result_valid,
    output logic [11:0]        height_mm,
    output logic [1:0]         cell_class,
    output logic               was_filled,
    output logic               index_valid,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    import phb_pkg::*;

    localparam int DEPTH = CELLS_X * CELLS_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(CELLS_X);
    localparam int CW    = $clog2(CELLS_Y);

    // Configuration registers.
    logic [9:0]  cell_size_reg;
    logic [14:0] half_x_reg;
    logic [14:0] half_y_reg;
    logic [11:0] max_height_reg;
    logic [11:0] ground_reg;
    logic [11:0] obstacle_reg;

    // Sequencer and datapath registers.
    state_t      state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] addr_reg;
    logic        is_query_reg;
    logic [11:0] z_reg;
    logic [15:0] row_reg;
    logic [15:0] col_reg;
    logic [26:0] prod_r1_reg;
    logic [26:0] prod_r2_reg;
    logic [26:0] prod_c1_reg;
    logic [26:0] prod_c2_reg;
    logic        row_hi_ok_reg;
    logic        col_hi_ok_reg;
    logic [1:0]  dr_reg;
    logic [1:0]  dc_reg;
    logic        pend_reg;
    logic [15:0] sum_reg;
    logic [3:0]  cnt_reg;
    logic        result_valid_reg;
    logic [11:0] height_reg;
    logic [1:0]  class_reg;
    logic        filled_reg;
    logic        index_valid_reg;

    // Combinational signals.
    logic [9:0]  cell_eff;
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [16:0] dx;
    logic [16:0] dy;
    logic        z_ok;
    logic        point_go;
    logic        in_map;
    logic        row_hi_ok;
    logic        col_hi_ok;
    logic [RW:0] nb_r;
    logic [CW:0] nb_c;
    logic        nb_ok;
    logic        nb_last;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [12:0] ram_wdata;
    logic [12:0] ram_rdata;
    logic        cell_occ;
    logic [11:0] cell_h;
    logic        acc_hit;
    logic        div_x_start;
    logic        div_y_start;
    logic [15:0] div_x_dividend;
    logic [9:0]  div_x_divisor;
    logic        div_x_done;
    logic        div_y_done;
    logic [15:0] div_x_quo;
    logic [15:0] div_y_quo;
    logic        emit;
    logic [11:0] emit_height;
    logic [1:0]  emit_class;
    logic        emit_filled;
    logic        emit_valid;

    // Flat address of a cell.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(CELLS_Y) + AW'(c);
    endfunction

    // Class of a measured height; ground wins over obstacle.
    function automatic logic [1:0] classify(input logic [11:0] h, input logic [11:0] gnd,
                                            input logic [11:0] obs);
        if (h < gnd)
        begin
            classify = CLASS_GROUND;
        end
        else if (h > obs)
        begin
            classify = CLASS_OBSTACLE;
        end
        else
        begin
            classify = CLASS_BETWEEN;
        end
    endfunction

    // Geometry and point screening.
    always_comb
    begin
        cell_eff  = (cell_size_reg == 10'd0) ? 10'd1 : cell_size_reg;
        span_x    = {half_x_reg, 1'b0};
        span_y    = {half_y_reg, 1'b0};
        dx        = {2'b00, half_x_reg} - {x_mm[15], x_mm};
        dy        = {2'b00, half_y_reg} - {y_mm[15], y_mm};
        z_ok      = !z_mm[15] && (z_mm[14:0] <= {3'b000, max_height_reg});
        point_go  = z_ok && !dx[16] && !dy[16];
        in_map    = (row_reg < 16'(CELLS_X)) && (col_reg < 16'(CELLS_Y))
                    && (prod_r1_reg <= {11'd0, span_x}) && (prod_c1_reg <= {11'd0, span_y});
        row_hi_ok = (17'(row_reg) + 17'd1 < 17'(CELLS_X)) && (prod_r2_reg <= {11'd0, span_x});
        col_hi_ok = (17'(col_reg) + 17'd1 < 17'(CELLS_Y)) && (prod_c2_reg <= {11'd0, span_y});
    end

    // Neighbour window position and bounds.
    always_comb
    begin
        nb_r    = {1'b0, row_reg[RW-1:0]} + (RW+1)'(dr_reg) - (RW+1)'(1);
        nb_c    = {1'b0, col_reg[CW-1:0]} + (CW+1)'(dc_reg) - (CW+1)'(1);
        nb_ok   = (dr_reg != 2'd0 || row_reg != 16'd0) && (dr_reg != 2'd2 || row_hi_ok_reg)
                  && (dc_reg != 2'd0 || col_reg != 16'd0) && (dc_reg != 2'd2 || col_hi_ok_reg)
                  && !(dr_reg == 2'd1 && dc_reg == 2'd1);
        nb_last = dr_reg == 2'd2 && dc_reg == 2'd2;
        cell_occ = ram_rdata[12];
        cell_h   = ram_rdata[11:0];
        acc_hit  = pend_reg && cell_occ && (cell_h < ground_reg);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode_t'(opcode))
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_POINT: state_next = point_go ? S_P_DIV : S_IDLE;
                        OP_QUERY: state_next = S_CHK;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_P_DIV:  state_next = div_x_done ? S_CHK : S_P_DIV;
            S_CHK:    state_next = is_query_reg ? S_Q_RD0 : S_P_ADDR;
            S_P_ADDR: state_next = in_map ? S_P_RD : S_IDLE;
            S_P_RD:   state_next = S_IDLE;
            S_Q_RD0:  state_next = in_map ? S_Q_C : S_IDLE;
            S_Q_C:    state_next = cell_occ ? S_IDLE : S_Q_NB;
            S_Q_NB:   state_next = nb_last ? S_Q_LAST : S_Q_NB;
            S_Q_LAST: state_next = S_Q_SUM;
            S_Q_SUM:  state_next = (cnt_reg == 4'd0) ? S_IDLE : S_Q_DIV;
            S_Q_DIV:  state_next = div_x_done ? S_IDLE : S_Q_DIV;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM port, divider starts and result beat.
    always_comb
    begin
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = {1'b1, z_reg};
        div_x_start    = 1'b0;
        div_y_start    = 1'b0;
        div_x_dividend = dx[15:0];
        div_x_divisor  = cell_eff;
        emit           = 1'b0;
        emit_height    = 12'd0;
        emit_class     = CLASS_NONE;
        emit_filled    = 1'b0;
        emit_valid     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = 13'd0;
            end
            S_IDLE:
            begin
                if (start && opcode_t'(opcode) == OP_POINT && point_go)
                begin
                    div_x_start = 1'b1;
                    div_y_start = 1'b1;
                end
            end
            S_P_ADDR:
            begin
                ram_addr = cell_addr(row_reg[RW-1:0], col_reg[CW-1:0]);
            end
            S_P_RD:
            begin
                ram_we = !cell_occ || (z_reg > cell_h);
            end
            S_Q_RD0:
            begin
                ram_addr = cell_addr(row_reg[RW-1:0], col_reg[CW-1:0]);
                emit     = !in_map;
            end
            S_Q_C:
            begin
                emit        = cell_occ;
                emit_valid  = 1'b1;
                emit_height = cell_h;
                emit_class  = classify(cell_h, ground_reg, obstacle_reg);
            end
            S_Q_NB:
            begin
                ram_addr = cell_addr(nb_r[RW-1:0], nb_c[CW-1:0]);
            end
            S_Q_SUM:
            begin
                emit           = cnt_reg == 4'd0;
                emit_valid     = 1'b1;
                div_x_start    = cnt_reg != 4'd0;
                div_x_dividend = sum_reg;
                div_x_divisor  = {6'd0, cnt_reg};
            end
            S_Q_DIV:
            begin
                emit        = div_x_done;
                emit_valid  = 1'b1;
                emit_height = div_x_quo[11:0];
                emit_filled = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            cell_size_reg    <= RST_CELL_SIZE;
            half_x_reg       <= RST_HALF;
            half_y_reg       <= RST_HALF;
            max_height_reg   <= RST_MAX_HEIGHT;
            ground_reg       <= RST_GROUND;
            obstacle_reg     <= RST_OBSTACLE;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else
            begin
                clr_addr_reg <= '0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CELL_SIZE:  cell_size_reg  <= cfg_data[9:0];
                    CFG_HALF_X:     half_x_reg     <= cfg_data;
                    CFG_HALF_Y:     half_y_reg     <= cfg_data;
                    CFG_MAX_HEIGHT: max_height_reg <= cfg_data[11:0];
                    CFG_GROUND:     ground_reg     <= cfg_data[11:0];
                    CFG_OBSTACLE:   obstacle_reg   <= cfg_data[11:0];
                    default:        ground_reg     <= ground_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            height_reg      <= emit_height;
            class_reg       <= emit_class;
            filled_reg      <= emit_filled;
            index_valid_reg <= emit_valid;
        end
        case (state_reg)
            S_IDLE:
            begin
                is_query_reg <= opcode_t'(opcode) == OP_QUERY;
                z_reg        <= z_mm[11:0];
                row_reg      <= {9'd0, query_row};
                col_reg      <= {9'd0, query_col};
            end
            S_P_DIV:
            begin
                row_reg <= div_x_quo;
                col_reg <= div_y_quo;
            end
            S_CHK:
            begin
                prod_r1_reg <= (17'(row_reg) + 17'd1) * cell_eff;
                prod_r2_reg <= (17'(row_reg) + 17'd2) * cell_eff;
                prod_c1_reg <= (17'(col_reg) + 17'd1) * cell_eff;
                prod_c2_reg <= (17'(col_reg) + 17'd2) * cell_eff;
            end
            S_P_ADDR:
            begin
                addr_reg <= ram_addr;
            end
            S_Q_RD0:
            begin
                row_hi_ok_reg <= row_hi_ok;
                col_hi_ok_reg <= col_hi_ok;
            end
            S_Q_C:
            begin
                dr_reg   <= 2'd0;
                dc_reg   <= 2'd0;
                pend_reg <= 1'b0;
                sum_reg  <= 16'd0;
                cnt_reg  <= 4'd0;
            end
            S_Q_NB, S_Q_LAST:
            begin
                pend_reg <= (state_reg == S_Q_NB) && nb_ok;
                if (dc_reg == 2'd2)
                begin
                    dc_reg <= 2'd0;
                    dr_reg <= dr_reg + 2'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 2'd1;
                end
                if (acc_hit)
                begin
                    sum_reg <= sum_reg + {4'd0, cell_h};
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
            default:
            begin
                pend_reg <= 1'b0;
            end
        endcase
    end

    // Grid store: occupied flag over the 12-bit height.
    phb_ram #(
        .WIDTH(13),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Row divider, also used for the neighbour average.
    phb_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_x_start),
        .dividend(div_x_dividend),
        .divisor (div_x_divisor),
        .done    (div_x_done),
        .quotient(div_x_quo)
    );

    // Column divider.
    phb_div u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_y_start),
        .dividend(dy[15:0]),
        .divisor (cell_eff),
        .done    (div_y_done),
        .quotient(div_y_quo)
    );

    assign busy         = (state_reg != S_IDLE) || (div_y_done && state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign height_mm    = height_reg;
    assign cell_class   = class_reg;
    assign was_filled   = filled_reg;
    assign index_valid  = index_valid_reg;

endmodule

/* design/phb_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module phb_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/phb_div.sv */
// Restoring radix-2 divider, 16-bit dividend by 10-bit divisor, one bit per cycle.
module phb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [15:0] quo_reg;
    logic [9:0]  rem_reg;
    logic [9:0]  dvs_reg;
    logic [4:0]  step_reg;
    logic        done_reg;
    logic [10:0] shifted;
    logic [10:0] diff;
    logic        fits;

    // One trial subtraction per step.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[15]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 5'd0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= 5'd16;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= step_reg == 5'd1;
            if (step_reg != 5'd0)
            begin
                step_reg <= step_reg - 5'd1;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 10'd0;
            dvs_reg <= divisor;
        end
        else if (step_reg != 5'd0)
        begin
            quo_reg <= {quo_reg[14:0], fits};
            rem_reg <= fits ? diff[9:0] : shifted[9:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/phb_checker.sv */
// Port-level checker of the point height grid builder and its bind.
module phb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input logic [11:0] height_mm,
    input logic [1:0]  cell_class,
    input logic        was_filled,
    input logic        index_valid
);

    import phb_pkg::*;

`include "point_heightmap_builder_assert.svh"

    // A result beat always closes a busy period.
    `PHB_ASSERT_SAME(a_result_after_busy, result_valid, $past(busy))

    // One query gives one beat, never two in a row.
    `PHB_ASSERT_NEXT(a_single_beat, result_valid, !result_valid)

    // A cell outside the map reports all zero.
    `PHB_ASSERT_SAME(a_outside_zero, result_valid && !index_valid,
                     height_mm == 12'd0 && cell_class == CLASS_NONE && !was_filled)

    // A filled height belongs to an empty cell inside the map.
    `PHB_ASSERT_SAME(a_filled_no_class, result_valid && was_filled,
                     cell_class == CLASS_NONE && index_valid)

endmodule

bind point_heightmap_builder phb_checker u_phb_checker (.*);
